>>> hw/rtl/tcce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int OP_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_SETCUR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Character codes
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  // Attribute after reset
  localparam logic [7:0] RESET_ATTR = 8'd7;

  // Memory access request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcce_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_cell_ram (
  input  wire logic                            clk,
  input  wire tcce_pkg::mem_req_t              req,
  output logic [tcce_pkg::CELL_W-1:0]          rdata
);

  logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELLS];
  logic [tcce_pkg::CELL_W-1:0] rdata_r;

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/tcce_addr_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_addr_unit (
  input  wire logic [tcce_pkg::ROW_W-1:0]  row,
  input  wire logic [tcce_pkg::ADDR_W-1:0] col,
  output logic      [tcce_pkg::ADDR_W-1:0] addr
);

  logic [tcce_pkg::ADDR_W:0] prod;
  logic [tcce_pkg::ADDR_W:0] sum;

  // Linear cell index: row times the row pitch plus the column offset
  always_comb begin
    prod = (tcce_pkg::ADDR_W+1)'(row) * (tcce_pkg::ADDR_W+1)'(tcce_pkg::COLUMNS);
    sum  = prod + (tcce_pkg::ADDR_W+1)'(col);
    addr = sum[tcce_pkg::ADDR_W-1:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcce_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module tcce_sequencer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [tcce_pkg::OP_W-1:0]    in_operation,
  input  wire logic [7:0]                   in_char_code,
  input  wire logic [tcce_pkg::COL_W-1:0]   in_column,
  input  wire logic [tcce_pkg::ROW_W-1:0]   in_row,
  input  wire logic [7:0]                   attr,
  output tcce_pkg::mem_req_t                mem_req,
  input  wire logic [tcce_pkg::CELL_W-1:0]  mem_rdata,
  output logic                              out_valid,
  output logic [tcce_pkg::COL_W-1:0]        out_cursor_column,
  output logic [tcce_pkg::ROW_W-1:0]        out_cursor_row,
  output logic [7:0]                        out_cell_char,
  output logic [7:0]                        out_cell_attribute
);

  localparam int AW = tcce_pkg::ADDR_W;
  localparam int CW = tcce_pkg::COL_W;
  localparam int RW = tcce_pkg::ROW_W;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_PUT      = 4'd2;
  localparam logic [3:0] S_FILL     = 4'd3;
  localparam logic [3:0] S_SCROLL   = 4'd4;
  localparam logic [3:0] S_SCR_TAIL = 4'd5;
  localparam logic [3:0] S_WRITE    = 4'd6;
  localparam logic [3:0] S_BS_RD    = 4'd7;
  localparam logic [3:0] S_BS_WR    = 4'd8;
  localparam logic [3:0] S_READ     = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  localparam logic [AW-1:0] PTR_LAST = AW'(tcce_pkg::CELLS - 1);
  localparam logic [AW-1:0] COPY_END = AW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS);
  localparam logic [CW-1:0] COL_MAX  = CW'(tcce_pkg::COLUMNS - 1);
  localparam logic [CW-1:0] COL_WRAP = CW'(tcce_pkg::COLUMNS);
  localparam logic [RW-1:0] ROW_MAX  = RW'(tcce_pkg::ROWS - 1);

  logic [3:0]                state_r, state_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt;
  logic [tcce_pkg::OP_W-1:0] op_r, op_nxt;
  logic [7:0]                char_r, char_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [CW-1:0]             cur_col_r, cur_col_nxt;
  logic [RW-1:0]             cur_row_r, cur_row_nxt;
  logic                      dly_v_r, dly_v_nxt;
  logic [AW-1:0]             dly_addr_r, dly_addr_nxt;
  logic                      dly_copy_r, dly_copy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CW-1:0]             out_col_r, out_col_nxt;
  logic [RW-1:0]             out_row_r, out_row_nxt;
  logic [7:0]                out_char_r, out_char_nxt;
  logic [7:0]                out_attr_r, out_attr_nxt;

  logic [RW-1:0]             au_row;
  logic [AW-1:0]             au_col;
  logic [AW-1:0]             au_addr;
  logic [CW-1:0]             sat_col;
  logic [RW-1:0]             sat_row;
  logic                      copy_phase;
  logic [tcce_pkg::CELL_W-1:0] blank;

  // Shared index unit
  tcce_addr_unit u_addr (
    .row  (au_row),
    .col  (au_col),
    .addr (au_addr)
  );

  assign sat_col    = (col_r >= COL_WRAP) ? COL_MAX : col_r;
  assign sat_row    = (row_r > ROW_MAX) ? ROW_MAX : row_r;
  assign copy_phase = (ptr_r < COPY_END);
  assign blank      = {attr, tcce_pkg::CODE_SPACE};

  // Steer the index unit: scroll source, read position or cursor
  always_comb begin
    case (state_r)
      S_SCROLL: begin
        au_row = RW'(1);
        au_col = ptr_r;
      end
      S_READ: begin
        au_row = sat_row;
        au_col = AW'(sat_col);
      end
      default: begin
        au_row = cur_row_r;
        au_col = AW'(cur_col_r);
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    op_nxt        = op_r;
    char_nxt      = char_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    dly_v_nxt     = 1'b0;
    dly_addr_nxt  = dly_addr_r;
    dly_copy_nxt  = dly_copy_r;
    out_valid_nxt = 1'b0;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    mem_req       = '0;

    case (state_r)
      // Clearing pass after reset
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = {tcce_pkg::RESET_ATTR, tcce_pkg::CODE_SPACE};
        ptr_nxt       = ptr_r + 1'b1;
        if (ptr_r == PTR_LAST) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // Take a transaction and dispatch on the operation
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_operation;
          char_nxt = in_char_code;
          col_nxt  = in_column;
          row_nxt  = in_row;
          ptr_nxt  = '0;
          case (in_operation)
            tcce_pkg::OP_PUT:   state_nxt = S_PUT;
            tcce_pkg::OP_CLEAR: state_nxt = S_FILL;
            tcce_pkg::OP_SETCUR: begin
              cur_col_nxt = (in_column >= COL_WRAP) ? COL_MAX : in_column;
              cur_row_nxt = (in_row > ROW_MAX) ? ROW_MAX : in_row;
              state_nxt   = S_DONE;
            end
            default: state_nxt = S_READ;
          endcase
        end
      end

      // Cursor movement for a put
      S_PUT: begin
        if (char_r == tcce_pkg::CODE_NEWLINE) begin
          cur_col_nxt = '0;
          if (cur_row_r == ROW_MAX) begin
            state_nxt = S_SCROLL;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            state_nxt   = S_DONE;
          end
        end else if (char_r == tcce_pkg::CODE_BACKSPACE) begin
          if (cur_col_r != '0) begin
            cur_col_nxt = cur_col_r - 1'b1;
          end else if (cur_row_r != '0) begin
            cur_row_nxt = cur_row_r - 1'b1;
            cur_col_nxt = COL_MAX;
          end
          state_nxt = S_BS_RD;
        end else if (cur_col_r >= COL_WRAP) begin
          cur_col_nxt = '0;
          if (cur_row_r == ROW_MAX) begin
            state_nxt = S_SCROLL;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            state_nxt   = S_WRITE;
          end
        end else begin
          state_nxt = S_WRITE;
        end
      end

      // Fill the screen with blanks in the current attribute
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = blank;
        ptr_nxt       = ptr_r + 1'b1;
        if (ptr_r == PTR_LAST) begin
          ptr_nxt     = '0;
          cur_col_nxt = '0;
          cur_row_nxt = '0;
          state_nxt   = S_DONE;
        end
      end

      // Scroll: read one row down, write it back in the next cycle; blank the last row
      S_SCROLL: begin
        mem_req.re    = copy_phase;
        mem_req.raddr = au_addr;
        mem_req.we    = dly_v_r;
        mem_req.waddr = dly_addr_r;
        mem_req.wdata = dly_copy_r ? mem_rdata : blank;
        dly_v_nxt     = 1'b1;
        dly_addr_nxt  = ptr_r;
        dly_copy_nxt  = copy_phase;
        ptr_nxt       = ptr_r + 1'b1;
        if (ptr_r == PTR_LAST) begin
          ptr_nxt   = '0;
          state_nxt = S_SCR_TAIL;
        end
      end

      // Drain the last delayed write of the scroll
      S_SCR_TAIL: begin
        mem_req.we    = dly_v_r;
        mem_req.waddr = dly_addr_r;
        mem_req.wdata = dly_copy_r ? mem_rdata : blank;
        cur_row_nxt   = ROW_MAX;
        state_nxt     = (char_r == tcce_pkg::CODE_NEWLINE) ? S_DONE : S_WRITE;
      end

      // Write a printable character and advance
      S_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = au_addr;
        mem_req.wdata = {attr, char_r};
        cur_col_nxt   = cur_col_r + 1'b1;
        state_nxt     = S_DONE;
      end

      // Backspace: fetch the cell, then blank its character only
      S_BS_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = au_addr;
        state_nxt     = S_BS_WR;
      end

      S_BS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = au_addr;
        mem_req.wdata = {mem_rdata[15:8], tcce_pkg::CODE_SPACE};
        state_nxt     = S_DONE;
      end

      // Read cell at the saturated position
      S_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = au_addr;
        state_nxt     = S_DONE;
      end

      // Register the result
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_col_nxt   = cur_col_r;
        out_row_nxt   = cur_row_r;
        if (op_r == tcce_pkg::OP_READ) begin
          out_char_nxt = mem_rdata[7:0];
          out_attr_nxt = mem_rdata[15:8];
        end else begin
          out_char_nxt = '0;
          out_attr_nxt = '0;
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      dly_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      dly_v_r     <= dly_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    dly_addr_r <= dly_addr_nxt;
    dly_copy_r <= dly_copy_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cursor_column  = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attribute = out_attr_r;

  // Cursor row never leaves the screen
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_row_r <= ROW_MAX)
    else $error("cursor row out of range");

  // Cursor column at most the wrap-pending value
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_col_r <= COL_WRAP)
    else $error("cursor column out of range");

  // Store writes stay inside the screen
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (mem_req.waddr <= PTR_LAST))
    else $error("store write beyond the screen");

  // A result strobe lasts one cycle and comes with the block ready
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!busy && $past(state_r) == S_DONE))
    else $error("result strobe outside its slot");

endmodule

`default_nettype wire

>>> hw/rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Operations: set cursor, read cell, put (printable, newline, backspace) and clear;
//   a scroll and a clear each make one pass over all rows*columns cells.
// One transaction at a time; busy stays high until the result strobe.
// Cells move through the single port pair of the screen store, driven by its sequencer.
// Reset: synchronous, active low; a clearing pass over rows*columns (2000) cells follows,
//   busy high meanwhile. Results cannot be stalled by the receiver.

module text_console_cursor_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tcce_pkg::OP_W-1:0]   in_operation,
  input  wire logic [7:0]                  in_char_code,
  input  wire logic [tcce_pkg::COL_W-1:0]  in_column,
  input  wire logic [tcce_pkg::ROW_W-1:0]  in_row,
  output logic                             out_valid,
  output logic [tcce_pkg::COL_W-1:0]       out_cursor_column,
  output logic [tcce_pkg::ROW_W-1:0]       out_cursor_row,
  output logic [7:0]                       out_cell_char,
  output logic [7:0]                       out_cell_attribute,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [7:0]                    attr_r;
  logic                          cfg_write;
  logic                          cfg_hit;
  tcce_pkg::mem_req_t            mem_req;
  logic [tcce_pkg::CELL_W-1:0]   mem_rdata;

  // Attribute register, decoded for byte addresses zero to three
  assign pready    = 1'b1;
  assign cfg_hit   = (paddr[2] == 1'b0);
  assign cfg_write = psel & penable & pwrite & pready & cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcce_pkg::RESET_ATTR;
    end else if (cfg_write) begin
      attr_r <= pwdata[7:0];
    end
  end

  assign prdata = cfg_hit ? {24'd0, attr_r} : 32'd0;

  tcce_sequencer u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_char_code       (in_char_code),
    .in_column          (in_column),
    .in_row             (in_row),
    .attr               (attr_r),
    .mem_req            (mem_req),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row),
    .out_cell_char      (out_cell_char),
    .out_cell_attribute (out_cell_attribute)
  );

  tcce_cell_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
